>>> sv/itcf_pkg.sv
`default_nettype none
package itcf_pkg;
  localparam int AtanIter = 16;
  localparam int ZW = 24;
  localparam int XW = 34;
  localparam logic [ZW-1:0] PI_Q20 = 24'd3294199;

  localparam logic [2:0] REG_RANGE   = 3'd0;
  localparam logic [2:0] REG_XBIAS   = 3'd1;
  localparam logic [2:0] REG_YBIAS   = 3'd2;
  localparam logic [2:0] REG_WEIGHT  = 3'd3;
  localparam logic [2:0] REG_TIMEOUT = 3'd4;

  function automatic logic [ZW-1:0] atan_lut(input logic [4:0] i);
    logic [ZW-1:0] v;
    case (i)
      5'd0: v = 24'd823550;   5'd1: v = 24'd486170;
      5'd2: v = 24'd256879;   5'd3: v = 24'd130396;
      5'd4: v = 24'd65451;    5'd5: v = 24'd32757;
      5'd6: v = 24'd16383;    5'd7: v = 24'd8192;
      5'd8: v = 24'd4096;     5'd9: v = 24'd2048;
      5'd10: v = 24'd1024;    5'd11: v = 24'd512;
      5'd12: v = 24'd256;     5'd13: v = 24'd128;
      5'd14: v = 24'd64;      5'd15: v = 24'd32;
      5'd16: v = 24'd16;      5'd17: v = 24'd8;
      5'd18: v = 24'd4;       5'd19: v = 24'd2;
      5'd20: v = 24'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [25:0] rate_lut(input logic [1:0] r);
    logic [25:0] v;
    case (r)
      2'd0: v = 26'd4687297;
      2'd1: v = 26'd9375207;
      2'd2: v = 26'd18721553;
      default: v = 26'd37443719;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

>>> sv/imu_tilt_complementary_filter_core.sv
`default_nettype none
// Complementary tilt filter, one sample in flight at a time. Both CORDIC atan2
// units run 16 rotations in parallel; a snapped sample then skips the
// multiplier and goes to the output register. For a blended sample, one
// bit-serial multiplier, shared by both axes, takes one bit of its b operand
// per cycle, first for dt*K (23 to 26 bits, once per sample), then
// per axis for the gyro increment (up to 42 bits of dt*K), alpha and
// 1024-alpha. The next transfer is taken once the result sits in the output
// register; a result still waiting there holds the following finished sample.
module imu_tilt_complementary_filter_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_accel_x,
  input  wire logic signed [15:0] in_accel_y,
  input  wire logic signed [15:0] in_accel_z,
  input  wire logic signed [15:0] in_gyro_x,
  input  wire logic signed [15:0] in_gyro_y,
  input  wire logic [31:0]        in_tick_ms,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_tilt_x,
  output logic signed [15:0]      out_tilt_y,
  output logic                    out_snapped,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import itcf_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_ATAN = 3'd1, S_GYRO = 3'd2,
                         S_BLA = 3'd3, S_BLB = 3'd4, S_NEXT = 3'd5, S_OUT = 3'd6,
                         S_DTK = 3'd7;

  logic [1:0] range_r;
  logic signed [15:0] xbias_r, ybias_r;
  logic [10:0] weight_r;
  logic [15:0] timeout_r;
  logic signed [15:0] ang_x_r, ang_y_r;
  logic [31:0] last_r;
  logic [15:0] dt_r;
  logic [41:0] dtk_r;
  logic [2:0] st_r;
  logic axis_r, snap_r, phase_r;
  logic signed [15:0] gx_r, gy_r, acc_x_r, acc_y_r;
  logic signed [75:0] sum_r;
  logic signed [37:0] pi_r;

  logic cx_done, cy_done, m_done, m_start;
  logic signed [15:0] cx_ang, cy_ang;
  logic signed [37:0] m_a;
  logic [57:0] m_b;
  logic signed [75:0] m_prod;
  logic in_xfer, launch;
  logic [10:0] a_eff;
  logic signed [17:0] rate;
  logic signed [15:0] acc_cur, ang_cur;
  logic signed [75:0] inc_full, bl_full;
  logic signed [15:0] blend_res;
  logic signed [37:0] pi_full;

  assign in_stall = (st_r != S_IDLE);
  assign in_xfer = in_valid && !in_stall;
  assign a_eff = (weight_r > 11'd1024) ? 11'd1024 : weight_r;

  itcf_cordic u_cx (.clk, .rst_n, .start(in_xfer), .num(in_accel_x), .den(in_accel_z),
                    .done(cx_done), .angle(cx_ang));
  itcf_cordic u_cy (.clk, .rst_n, .start(in_xfer), .num(in_accel_y), .den(in_accel_z),
                    .done(cy_done), .angle(cy_ang));
  itcf_serial_mul u_mul (.clk, .rst_n, .start(m_start), .a(m_a), .b(m_b),
                         .done(m_done), .prod(m_prod));

  // rate for current axis: x uses -(gy-bias), y uses gx-bias
  assign rate = axis_r ? (18'(gx_r) - 18'(xbias_r)) : (18'(ybias_r) - 18'(gy_r));
  assign acc_cur = axis_r ? acc_y_r : acc_x_r;
  assign ang_cur = axis_r ? ang_y_r : ang_x_r;
  assign inc_full = (m_prod + 76'sd2147483648) >>> 32;
  assign bl_full = (sum_r + m_prod + 76'sd512) >>> 10;
  assign blend_res = (bl_full > 76'sd32767) ? 16'sh7fff :
                     (bl_full < -76'sd32768) ? 16'sh8000 : bl_full[15:0];

  // prev+inc reaches about 26 bits at the longest gap; keep it whole
  assign pi_full = 38'(ang_cur) + 38'(inc_full);

  // each multiply stage: launch cycle, then wait for done
  assign launch = !phase_r &&
                  (st_r == S_DTK || st_r == S_GYRO || st_r == S_BLA || st_r == S_BLB);
  assign m_start = launch;

  always_comb begin
    m_a = '0; m_b = '0;
    unique case (st_r)
      S_DTK:  begin m_a = 38'(dt_r); m_b = 58'(rate_lut(range_r)); end
      S_GYRO: begin m_a = 38'(rate); m_b = 58'(dtk_r); end
      S_BLA:  begin m_a = 38'(acc_cur); m_b = 58'(a_eff); end
      S_BLB:  begin m_a = pi_r; m_b = 58'(11'd1024 - a_eff); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= '0; xbias_r <= '0; ybias_r <= '0;
      weight_r <= 11'd102; timeout_r <= 16'd50;
      ang_x_r <= '0; ang_y_r <= '0; last_r <= '0;
      st_r <= S_IDLE; out_valid <= 1'b0; phase_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RANGE:   range_r <= cfg_data[1:0];
          REG_XBIAS:   xbias_r <= cfg_data;
          REG_YBIAS:   ybias_r <= cfg_data;
          REG_WEIGHT:  weight_r <= cfg_data[10:0];
          REG_TIMEOUT: timeout_r <= cfg_data;
          default: ;
        endcase
      end
      if (st_r == S_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (st_r)
        S_IDLE: if (in_xfer) begin
          // the gap only matters when it is within the 16-bit timeout
          dt_r <= 16'(in_tick_ms - last_r);
          snap_r <= (in_tick_ms - last_r) > 32'(timeout_r);
          last_r <= in_tick_ms;
          gx_r <= in_gyro_x; gy_r <= in_gyro_y;
          axis_r <= 1'b0; st_r <= S_ATAN;
        end
        S_ATAN: if (cx_done) begin
          acc_x_r <= cx_ang; acc_y_r <= cy_ang;
          st_r <= snap_r ? S_OUT : S_DTK; phase_r <= 1'b0;
        end
        S_DTK: begin
          if (!phase_r) begin phase_r <= 1'b1; end
          else if (m_done) begin
            dtk_r <= m_prod[41:0]; phase_r <= 1'b0; st_r <= S_GYRO;
          end
        end
        S_GYRO: begin
          if (!phase_r) begin phase_r <= 1'b1; end
          else if (m_done) begin
            pi_r <= pi_full; phase_r <= 1'b0; st_r <= S_BLA;
          end
        end
        S_BLA: begin
          if (!phase_r) begin phase_r <= 1'b1; end
          else if (m_done) begin
            sum_r <= m_prod; phase_r <= 1'b0; st_r <= S_BLB;
          end
        end
        S_BLB: begin
          if (!phase_r) begin phase_r <= 1'b1; end
          else if (m_done) begin
            phase_r <= 1'b0;
            if (axis_r) ang_y_r <= blend_res; else ang_x_r <= blend_res;
            st_r <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (axis_r) st_r <= S_OUT;
          else begin axis_r <= 1'b1; st_r <= S_GYRO; end
        end
        S_OUT: if (!out_valid || !out_stall) begin
          if (snap_r) begin
            out_tilt_x <= acc_x_r; out_tilt_y <= acc_y_r;
            ang_x_r <= acc_x_r; ang_y_r <= acc_y_r;
          end else begin
            out_tilt_x <= ang_x_r; out_tilt_y <= ang_y_r;
          end
          out_snapped <= snap_r; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) in_xfer |=> in_stall)
    else $error("accepted sample while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_tilt_x)))
    else $error("result lost under stall");
  assert property (@(posedge clk) disable iff (!rst_n) cx_done |-> cy_done)
    else $error("cordic units out of step");
endmodule
`default_nettype wire

>>> sv/itcf_cordic.sv
`default_nettype none
// Vectoring CORDIC, one rotation per cycle; result in Q2.13.
module itcf_cordic (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [15:0] num,
  input  wire logic signed [15:0] den,
  output logic                    done,
  output logic signed [15:0]      angle
);
  import itcf_pkg::*;
  logic signed [XW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic [4:0] i_r, i_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic signed [XW-1:0] xs, ys, x0, y0;
  logic signed [ZW:0] zr;

  assign x0 = XW'(den) <<< 14;
  assign y0 = XW'(num) <<< 14;
  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign zr = ZW'(z_r + ZW'(64)) >>> 7;
  assign angle = zr[15:0];
  assign done = done_r;

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; i_nxt = i_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      i_nxt = '0; busy_nxt = 1'b1;
      if (den < 0) begin
        x_nxt = -x0; y_nxt = -y0;
        z_nxt = (num >= 0) ? PI_Q20 : -PI_Q20;
      end else begin
        x_nxt = x0; y_nxt = y0; z_nxt = '0;
      end
    end else if (busy_r) begin
      if (y_r >= 0) begin
        x_nxt = x_r + ys; y_nxt = y_r - xs; z_nxt = z_r + atan_lut(i_r);
      end else begin
        x_nxt = x_r - ys; y_nxt = y_r + xs; z_nxt = z_r - atan_lut(i_r);
      end
      i_nxt = i_r + 5'd1;
      if (i_r == 5'(AtanIter - 1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; i_r <= i_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end
endmodule
`default_nettype wire

>>> sv/itcf_serial_mul.sv
`default_nettype none
// Shift-add multiplier, one multiplier bit per cycle (unsigned b, signed a).
module itcf_serial_mul (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [37:0] a,
  input  wire logic [57:0]        b,
  output logic                    done,
  output logic signed [75:0]      prod
);
  logic signed [75:0] acc_r, acc_nxt, a_r, a_nxt;
  logic [57:0] b_r, b_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  assign prod = acc_r;
  assign done = done_r;
  always_comb begin
    acc_nxt = acc_r; a_nxt = a_r; b_nxt = b_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      acc_nxt = '0; a_nxt = 76'(a); b_nxt = b; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) acc_nxt = acc_r + a_r;
      a_nxt = a_r <<< 1;
      b_nxt = b_r >> 1;
      if (b_r[57:1] == '0) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt; a_r <= a_nxt; b_r <= b_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end
endmodule
`default_nettype wire
